// File: rtl/core/waypoint_path_follower_defines.svh
// Assertion macros for the waypoint path follower.
`ifndef WAYPOINT_PATH_FOLLOWER_DEFINES_SVH
`define WAYPOINT_PATH_FOLLOWER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define WPF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define WPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/wpf_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the waypoint path follower.
package wpf_pkg;

  localparam int DEF_MAX_POINTS = 64;
  localparam int COORD_W   = 24;
  localparam int CFG_W     = 16;
  localparam int IDX_OUT_W = 7;
  localparam logic [IDX_OUT_W-1:0] IDX_NONE = '1;

  localparam int DIFF_W = 25;   // waypoint minus position
  localparam int D2_W   = 50;   // squared distance, even for the root
  localparam int LEN_W  = 25;   // floor root of the squared distance
  localparam int MUL_W  = 26;   // multiplier operand
  localparam int PROD_W = 52;
  localparam int NUM_W  = 44;   // divider numerator, signed
  localparam int DEN_W  = 26;   // divider denominator
  localparam int QUO_W  = 47;   // divider quotient, signed
  localparam int DES_W  = 18;   // desired velocity component

  localparam logic [D2_W-1:0] END_DIST_SQ = D2_W'(768 * 768);

  localparam logic [CFG_W-1:0] RST_MAX_VEL   = 16'd512;
  localparam logic [CFG_W-1:0] RST_MAX_FORCE = 16'd256;
  localparam logic [CFG_W-1:0] RST_ARRIVAL   = 16'd2560;

  localparam logic signed [QUO_W:0] SAT_HI = (QUO_W+1)'(2**(COORD_W-1) - 1);
  localparam logic signed [QUO_W:0] SAT_LO = ~SAT_HI;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_CLEAR  = 2'd1,
    ACT_TICK   = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    REG_MAX_VEL   = 2'd0,
    REG_MAX_FORCE = 2'd1,
    REG_ARRIVAL   = 2'd2,
    REG_CLEAR_END = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [CFG_W-1:0] speed_cap;
    logic [CFG_W-1:0] force_cap;
    logic [CFG_W-1:0] reach_radius;
    logic             clear_on_end;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE = 4'd0,
    OP_LOAD = 4'd1,
    OP_DIFF = 4'd2,
    OP_SQX  = 4'd3,
    OP_SQY  = 4'd4,
    OP_SQA  = 4'd5,
    OP_SQRT = 4'd6,
    OP_MUL  = 4'd7,
    OP_DIV  = 4'd8,
    OP_WB   = 4'd9,
    OP_HOLD = 4'd10
  } op_t;

  typedef enum logic [2:0] {
    PH_DESX = 3'd0,
    PH_DESY = 3'd1,
    PH_FX   = 3'd2,
    PH_FY   = 3'd3,
    PH_AX   = 3'd4,
    PH_AY   = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    SRC_IN  = 2'd0,
    SRC_RD  = 2'd1,
    SRC_TMP = 2'd2
  } src_t;

  typedef struct packed {
    op_t    op;
    phase_t phase;
    logic   mem_we;
    src_t   mem_src;
  } dp_cmd_t;

  typedef struct packed {
    logic near;
    logic near_end;
    logic len_zero;
    logic sq_busy;
    logic div_busy;
  } dp_stat_t;

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [QUO_W:0] v);
    if (v > SAT_HI) begin
      sat_coord = SAT_HI[COORD_W-1:0];
    end else if (v < SAT_LO) begin
      sat_coord = SAT_LO[COORD_W-1:0];
    end else begin
      sat_coord = v[COORD_W-1:0];
    end
  endfunction

endpackage

// File: rtl/core/wpf_if.sv
`timescale 1ns / 1ps
// Request and result channel interfaces of the waypoint path follower.
interface wpf_req_if import wpf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                action;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] vel_x;
  logic signed [COORD_W-1:0] vel_y;

  modport source (output valid, action, pos_x, pos_y, vel_x, vel_y, input ready);
  modport sink (input valid, action, pos_x, pos_y, vel_x, vel_y, output ready);
endinterface

interface wpf_rsp_if import wpf_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [COORD_W-1:0]   force_x;
  logic signed [COORD_W-1:0]   force_y;
  logic signed [IDX_OUT_W-1:0] current_index;
  logic                        stop_agent;
  logic                        status;

  modport source (output valid, force_x, force_y, current_index, stop_agent, status,
                  input ready);
  modport sink (input valid, force_x, force_y, current_index, stop_agent, status,
                output ready);
endinterface

// File: rtl/core/waypoint_path_follower.sv
`timescale 1ns / 1ps
// Top level of the waypoint path follower: config registers, result register, core.
//
//   channel  dir  handshake          payload
//   req      in   valid/ready        action, pos_x, pos_y, vel_x, vel_y
//   rsp      out  valid/ready        force_x, force_y, current_index, stop_agent, status
//   cfg      in   cfg_we             cfg_index, cfg_data
//
// One request at a time: a new request is taken only after the last result is emitted.
// A seek tick waits on the square root and then runs four division phases (two for a
// zero offset), each a 46-step divide on one shared divider. An arrive tick runs two
// division phases; an end stop clears the path or reverses it one pair at a time.
// Reset (rst, synchronous) empties the path and restores config defaults.
// A finished result waits in the output register while the next request is taken.
module waypoint_path_follower import wpf_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  logic             clk,
  input  logic             rst,
  wpf_req_if.sink          req,
  wpf_rsp_if.source        rsp,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  `include "waypoint_path_follower_defines.svh"

  localparam int IDX_W = $clog2(MAX_POINTS);

  cfg_t                      cfg;
  dp_cmd_t                   dp_cmd;
  dp_stat_t                  dp_stat;
  logic [IDX_W-1:0]          addr;
  logic                      emit;
  logic                      out_valid;
  logic                      out_free;
  logic                      req_fire;
  logic [IDX_OUT_W-1:0]      rsp_index;
  logic                      rsp_stop;
  logic                      rsp_status;
  logic signed [COORD_W-1:0] fx, fy;
  logic signed [COORD_W-1:0] out_fx, out_fy;
  logic [IDX_OUT_W-1:0]      out_index;
  logic                      out_stop;
  logic                      out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speed_cap    <= RST_MAX_VEL;
      cfg.force_cap    <= RST_MAX_FORCE;
      cfg.reach_radius <= RST_ARRIVAL;
      cfg.clear_on_end <= 1'b1;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_MAX_VEL:   cfg.speed_cap <= cfg_data;
        REG_MAX_FORCE: cfg.force_cap <= cfg_data;
        REG_ARRIVAL:   cfg.reach_radius <= cfg_data;
        REG_CLEAR_END: cfg.clear_on_end <= cfg_data[0];
        default:       cfg.clear_on_end <= cfg.clear_on_end;
      endcase
    end
  end

  assign req_fire = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;

  wpf_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_fire   (req_fire),
    .action     (req.action),
    .cfg        (cfg),
    .stat       (dp_stat),
    .out_free   (out_free),
    .cmd        (dp_cmd),
    .addr       (addr),
    .emit       (emit),
    .req_ready  (req.ready),
    .rsp_index  (rsp_index),
    .rsp_stop   (rsp_stop),
    .rsp_status (rsp_status)
  );

  wpf_dpath #(.MAX_POINTS(MAX_POINTS)) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (dp_cmd),
    .addr    (addr),
    .cfg     (cfg),
    .pos_x   (req.pos_x),
    .pos_y   (req.pos_y),
    .vel_x   (req.vel_x),
    .vel_y   (req.vel_y),
    .stat    (dp_stat),
    .force_x (fx),
    .force_y (fy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_fx     <= fx;
      out_fy     <= fy;
      out_index  <= rsp_index;
      out_stop   <= rsp_stop;
      out_status <= rsp_status;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.force_x       = out_fx;
  assign rsp.force_y       = out_fy;
  assign rsp.current_index = out_index;
  assign rsp.stop_agent    = out_stop;
  assign rsp.status        = out_status;

  `WPF_ASSERT_IMP(a_emit_free, emit, !out_valid || rsp.ready, "pending result overwritten")
  `WPF_ASSERT_IMP(a_accept_quiet, req.valid && req.ready, !dp_stat.sq_busy && !dp_stat.div_busy, "request taken while datapath busy")
  `WPF_ASSERT_IMP(a_stop_idle, rsp.valid && rsp.stop_agent, rsp.current_index == IDX_NONE && rsp.force_x == 0 && rsp.force_y == 0, "stop result not idle with zero force")
  `WPF_ASSERT_NEXT(a_emit_shown, emit, out_valid && out_index == $past(rsp_index), "emitted result not shown")

endmodule

// File: rtl/core/wpf_div.sv
`timescale 1ns / 1ps
// Radix-2 restoring divider, rounds to nearest with ties away from zero.
module wpf_div import wpf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output logic                    busy,
  output logic signed [QUO_W-1:0] quo
);

  localparam int DIVD_W = NUM_W + 2;   // 2|n| + d
  localparam int DVS_W  = DEN_W + 1;   // 2d
  localparam int CNT_W  = $clog2(DIVD_W + 1);

  logic [DIVD_W-1:0] dvd;
  logic [DVS_W-1:0]  dvs;
  logic [DVS_W-1:0]  rem;
  logic [CNT_W-1:0]  cnt;
  logic              neg;
  logic [NUM_W-1:0]  mag;
  logic [DVS_W:0]    part;
  logic              qbit;

  always_comb begin
    mag  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    part = {rem, dvd[DIVD_W-1]};
    qbit = part >= (DVS_W+1)'(dvs);
  end

  // quotient bits shift into the dividend register as it empties
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      dvd <= DIVD_W'({mag, 1'b0}) + DIVD_W'(den);
      dvs <= {den, 1'b0};
      rem <= '0;
      neg <= num[NUM_W-1];
      cnt <= CNT_W'(DIVD_W);
    end else if (cnt != '0) begin
      rem <= qbit ? DVS_W'(part - (DVS_W+1)'(dvs)) : part[DVS_W-1:0];
      dvd <= {dvd[DIVD_W-2:0], qbit};
      cnt <= cnt - 1'b1;
    end
  end

  assign busy = cnt != '0;
  assign quo  = neg ? -$signed({1'b0, dvd}) : $signed({1'b0, dvd});

endmodule

// File: rtl/core/wpf_dpath.sv
`timescale 1ns / 1ps
// Datapath: waypoint store, distance, square root and force arithmetic.
module wpf_dpath import wpf_pkg::*; #(
  parameter  int MAX_POINTS = DEF_MAX_POINTS,
  localparam int IDX_W      = $clog2(MAX_POINTS)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  dp_cmd_t                   cmd,
  input  logic [IDX_W-1:0]          addr,
  input  cfg_t                      cfg,
  input  logic signed [COORD_W-1:0] pos_x,
  input  logic signed [COORD_W-1:0] pos_y,
  input  logic signed [COORD_W-1:0] vel_x,
  input  logic signed [COORD_W-1:0] vel_y,
  output dp_stat_t                  stat,
  output logic signed [COORD_W-1:0] force_x,
  output logic signed [COORD_W-1:0] force_y
);

  localparam int SQ_CNT_W = $clog2(LEN_W + 1);

  logic signed [COORD_W-1:0] mem_x [MAX_POINTS];
  logic signed [COORD_W-1:0] mem_y [MAX_POINTS];
  logic signed [COORD_W-1:0] rd_x, rd_y, tmp_x, tmp_y, wr_x, wr_y;
  logic signed [COORD_W-1:0] px, py, vx, vy, fx, fy;
  logic signed [DIFF_W-1:0]  dx, dy;
  logic [D2_W-1:0]           d2;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [DES_W-1:0]   desx, desy;
  logic [D2_W-1:0]           sq_x;
  logic [LEN_W:0]            sq_rem;
  logic [LEN_W-1:0]          len;
  logic [SQ_CNT_W-1:0]       sq_cnt;
  logic [LEN_W+2:0]          sq_part;
  logic [LEN_W+2:0]          sq_trial;
  logic [DEN_W-1:0]          div_den;
  logic                      div_busy;
  logic signed [QUO_W-1:0]   quo;

  always_comb begin
    case (cmd.mem_src)
      SRC_RD: begin
        wr_x = rd_x;
        wr_y = rd_y;
      end
      SRC_TMP: begin
        wr_x = tmp_x;
        wr_y = tmp_y;
      end
      default: begin
        wr_x = px;
        wr_y = py;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem_x[addr] <= wr_x;
      mem_y[addr] <= wr_y;
    end
    rd_x <= mem_x[addr];
    rd_y <= mem_y[addr];
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_SQX: begin
        mul_a = MUL_W'(dx);
        mul_b = MUL_W'(dx);
      end
      OP_SQY: begin
        mul_a = MUL_W'(dy);
        mul_b = MUL_W'(dy);
      end
      OP_SQA: begin
        mul_a = MUL_W'({1'b0, cfg.reach_radius});
        mul_b = MUL_W'({1'b0, cfg.reach_radius});
      end
      OP_MUL: begin
        case (cmd.phase)
          PH_DESX, PH_AX: begin
            mul_a = MUL_W'(dx);
            mul_b = MUL_W'({1'b0, cfg.speed_cap});
          end
          PH_DESY, PH_AY: begin
            mul_a = MUL_W'(dy);
            mul_b = MUL_W'({1'b0, cfg.speed_cap});
          end
          PH_FX: begin
            mul_a = MUL_W'(desx) - MUL_W'(vx);
            mul_b = MUL_W'({1'b0, cfg.force_cap});
          end
          PH_FY: begin
            mul_a = MUL_W'(desy) - MUL_W'(vy);
            mul_b = MUL_W'({1'b0, cfg.force_cap});
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    case (cmd.phase)
      PH_DESX, PH_DESY: div_den = DEN_W'(len);
      PH_FX, PH_FY:     div_den = DEN_W'(cfg.speed_cap);
      default:          div_den = DEN_W'(cfg.reach_radius);
    endcase
  end

  // one root bit per cycle: bring down two radicand bits, try (root << 2) | 1
  always_comb begin
    sq_part  = {sq_rem, sq_x[D2_W-1 -: 2]};
    sq_trial = (LEN_W+3)'({len, 2'b01});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_cnt <= '0;
    end else if (cmd.op == OP_SQRT) begin
      sq_cnt <= SQ_CNT_W'(LEN_W);
    end else if (sq_cnt != '0) begin
      sq_cnt <= sq_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sq_cnt != '0) begin
      sq_x <= {sq_x[D2_W-3:0], 2'b00};
      if (sq_part >= sq_trial) begin
        sq_rem <= (LEN_W+1)'(sq_part - sq_trial);
        len    <= {len[LEN_W-2:0], 1'b1};
      end else begin
        sq_rem <= sq_part[LEN_W:0];
        len    <= {len[LEN_W-2:0], 1'b0};
      end
    end
    case (cmd.op)
      OP_LOAD: begin
        px <= pos_x;
        py <= pos_y;
        vx <= vel_x;
        vy <= vel_y;
        fx <= '0;
        fy <= '0;
      end
      OP_DIFF: begin
        dx <= DIFF_W'(rd_x) - DIFF_W'(px);
        dy <= DIFF_W'(rd_y) - DIFF_W'(py);
      end
      OP_SQX, OP_MUL: prod <= mul_a * mul_b;
      OP_SQY: begin
        d2   <= prod[D2_W-1:0];
        prod <= mul_a * mul_b;
      end
      OP_SQA: begin
        d2   <= d2 + prod[D2_W-1:0];
        prod <= mul_a * mul_b;
      end
      OP_SQRT: begin
        sq_x   <= d2;
        sq_rem <= '0;
        len    <= '0;
        desx   <= '0;
        desy   <= '0;
      end
      OP_HOLD: begin
        tmp_x <= rd_x;
        tmp_y <= rd_y;
      end
      OP_WB: begin
        case (cmd.phase)
          PH_DESX: desx <= quo[DES_W-1:0];
          PH_DESY: desy <= quo[DES_W-1:0];
          PH_FX:   fx <= sat_coord((QUO_W+1)'(quo));
          PH_FY:   fy <= sat_coord((QUO_W+1)'(quo));
          PH_AX:   fx <= sat_coord((QUO_W+1)'(quo) - (QUO_W+1)'(vx));
          PH_AY:   fy <= sat_coord((QUO_W+1)'(quo) - (QUO_W+1)'(vy));
          default: fx <= fx;
        endcase
      end
      default: prod <= prod;
    endcase
  end

  wpf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.op == OP_DIV),
    .num   ($signed(prod[NUM_W-1:0])),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (quo)
  );

  // during the compare step prod holds the reach radius squared
  assign stat.near     = d2 < prod[D2_W-1:0];
  assign stat.near_end = d2 < END_DIST_SQ;
  assign stat.len_zero = len == '0;
  assign stat.sq_busy  = sq_cnt != '0;
  assign stat.div_busy = div_busy;
  assign force_x       = fx;
  assign force_y       = fy;

endmodule

// File: rtl/core/wpf_ctrl.sv
`timescale 1ns / 1ps
// Controller: path state and the sequence of datapath steps for each request.
module wpf_ctrl import wpf_pkg::*; #(
  parameter  int MAX_POINTS = DEF_MAX_POINTS,
  localparam int IDX_W      = $clog2(MAX_POINTS),
  localparam int CNT_W      = $clog2(MAX_POINTS + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_fire,
  input  logic [1:0]           action,
  input  cfg_t                 cfg,
  input  dp_stat_t             stat,
  input  logic                 out_free,
  output dp_cmd_t              cmd,
  output logic [IDX_W-1:0]     addr,
  output logic                 emit,
  output logic                 req_ready,
  output logic [IDX_OUT_W-1:0] rsp_index,
  output logic                 rsp_stop,
  output logic                 rsp_status
);

  typedef enum logic [19:0] {
    S_IDLE   = 20'h00001,
    S_APPEND = 20'h00002,
    S_START  = 20'h00004,
    S_READ   = 20'h00008,
    S_DIFF   = 20'h00010,
    S_SQX    = 20'h00020,
    S_SQY    = 20'h00040,
    S_SQA    = 20'h00080,
    S_CMP    = 20'h00100,
    S_SQRT   = 20'h00200,
    S_SQRW   = 20'h00400,
    S_MUL    = 20'h00800,
    S_DIVS   = 20'h01000,
    S_DIVW   = 20'h02000,
    S_WB     = 20'h04000,
    S_REV_RA = 20'h08000,
    S_REV_RB = 20'h10000,
    S_REV_WA = 20'h20000,
    S_REV_WB = 20'h40000,
    S_DONE   = 20'h80000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] fidx, fidx_next;
  logic [IDX_W-1:0] ra, ra_next, rb, rb_next;
  logic             idle, idle_next;
  logic             advanced, advanced_next;
  phase_t           phase, phase_next;
  logic             stop, stop_next;
  logic             status, status_next;
  logic             last;

  assign last = CNT_W'(fidx) == count - 1'b1;

  always_comb begin
    state_next    = state;
    count_next    = count;
    fidx_next     = fidx;
    ra_next       = ra;
    rb_next       = rb;
    idle_next     = idle;
    advanced_next = advanced;
    phase_next    = phase;
    stop_next     = stop;
    status_next   = status;
    cmd.op        = OP_NONE;
    cmd.phase     = phase;
    cmd.mem_we    = 1'b0;
    cmd.mem_src   = SRC_IN;
    addr          = fidx;
    emit          = 1'b0;
    case (state)
      S_IDLE: begin
        if (req_fire) begin
          cmd.op      = OP_LOAD;
          stop_next   = 1'b0;
          status_next = 1'b0;
          case (action_t'(action))
            ACT_APPEND: begin
              if (count < CNT_W'(MAX_POINTS)) begin
                state_next = S_APPEND;
              end else begin
                status_next = 1'b1;
                state_next  = S_DONE;
              end
            end
            ACT_CLEAR: begin
              count_next = '0;
              idle_next  = 1'b1;
              state_next = S_DONE;
            end
            ACT_TICK: state_next = S_START;
            default:  state_next = S_DONE;
          endcase
        end
      end
      S_APPEND: begin
        cmd.mem_we = 1'b1;
        addr       = IDX_W'(count);
        count_next = count + 1'b1;
        state_next = S_DONE;
      end
      S_START: begin
        if (idle && count != '0) begin
          idle_next     = 1'b0;
          fidx_next     = '0;
          advanced_next = 1'b0;
          state_next    = S_READ;
        end else if (!idle) begin
          advanced_next = 1'b0;
          state_next    = S_READ;
        end else begin
          state_next = S_DONE;
        end
      end
      S_READ: state_next = S_DIFF;
      S_DIFF: begin
        cmd.op     = OP_DIFF;
        state_next = S_SQX;
      end
      S_SQX: begin
        cmd.op     = OP_SQX;
        state_next = S_SQY;
      end
      S_SQY: begin
        cmd.op     = OP_SQY;
        state_next = S_SQA;
      end
      S_SQA: begin
        cmd.op     = OP_SQA;
        state_next = S_CMP;
      end
      S_CMP: begin
        // after stepping to the next point the reach test is not repeated
        if (!advanced && stat.near && last) begin
          if (stat.near_end) begin
            stop_next = 1'b1;
            idle_next = 1'b1;
            if (cfg.clear_on_end) begin
              count_next = '0;
              state_next = S_DONE;
            end else begin
              ra_next    = '0;
              rb_next    = IDX_W'(count - 1'b1);
              state_next = S_REV_RA;
            end
          end else begin
            phase_next = PH_AX;
            state_next = S_MUL;
          end
        end else if (!advanced && stat.near) begin
          fidx_next     = fidx + 1'b1;
          advanced_next = 1'b1;
          state_next    = S_READ;
        end else if (cfg.speed_cap == '0) begin
          state_next = S_DONE;
        end else begin
          state_next = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.op     = OP_SQRT;
        state_next = S_SQRW;
      end
      S_SQRW: begin
        if (!stat.sq_busy) begin
          phase_next = stat.len_zero ? PH_FX : PH_DESX;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.op     = OP_MUL;
        state_next = S_DIVS;
      end
      S_DIVS: begin
        cmd.op     = OP_DIV;
        state_next = S_DIVW;
      end
      S_DIVW: begin
        if (!stat.div_busy) begin
          state_next = S_WB;
        end
      end
      S_WB: begin
        cmd.op = OP_WB;
        case (phase)
          PH_DESX: begin
            phase_next = PH_DESY;
            state_next = S_MUL;
          end
          PH_DESY: begin
            phase_next = PH_FX;
            state_next = S_MUL;
          end
          PH_FX: begin
            phase_next = PH_FY;
            state_next = S_MUL;
          end
          PH_AX: begin
            phase_next = PH_AY;
            state_next = S_MUL;
          end
          default: state_next = S_DONE;
        endcase
      end
      // swap one pair at a time through the single port: read a, read b, write a, write b
      S_REV_RA: begin
        if (ra < rb) begin
          addr       = ra;
          state_next = S_REV_RB;
        end else begin
          state_next = S_DONE;
        end
      end
      S_REV_RB: begin
        addr       = rb;
        cmd.op     = OP_HOLD;
        state_next = S_REV_WA;
      end
      S_REV_WA: begin
        addr        = ra;
        cmd.mem_we  = 1'b1;
        cmd.mem_src = SRC_RD;
        state_next  = S_REV_WB;
      end
      S_REV_WB: begin
        addr        = rb;
        cmd.mem_we  = 1'b1;
        cmd.mem_src = SRC_TMP;
        ra_next     = ra + 1'b1;
        rb_next     = rb - 1'b1;
        state_next  = S_REV_RA;
      end
      S_DONE: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      fidx     <= '0;
      ra       <= '0;
      rb       <= '0;
      idle     <= 1'b1;
      advanced <= 1'b0;
      phase    <= PH_DESX;
      stop     <= 1'b0;
      status   <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      fidx     <= fidx_next;
      ra       <= ra_next;
      rb       <= rb_next;
      idle     <= idle_next;
      advanced <= advanced_next;
      phase    <= phase_next;
      stop     <= stop_next;
      status   <= status_next;
    end
  end

  assign req_ready  = state == S_IDLE;
  assign rsp_index  = idle ? IDX_NONE : IDX_OUT_W'(fidx);
  assign rsp_stop   = stop;
  assign rsp_status = status;

endmodule
